// ===== design/fvc_pkg.sv =====
// Package for the follow velocity controller: widths, fixed-point constants,
// register indexes, command and status types and the CORDIC arctangent table.
// No dependencies; every other file of the block imports it.
package fvc_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;
  localparam int STEP_W            = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W        = 5;

  localparam int POS_W     = 16;
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int THR_W     = 15;
  localparam int SPEED_W   = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int CV_W      = 28;
  localparam int CV_SHIFT  = 8;
  localparam int ANG_W     = 20;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SQ_W      = 32;
  localparam int LEN_W     = 34;
  localparam int DIFF_W    = 32;
  localparam int UPD_W     = 34;

  localparam int LIN_SHIFT  = 4;
  localparam int ANG_SHIFT  = 8;
  localparam int FILT_SHIFT = 16;

  localparam logic signed [ANG_W-1:0]   PI_Q16        = 20'sd205887;
  localparam logic signed [ANG_W-1:0]   HEADING_LIMIT = 20'sd102892;
  localparam logic signed [MUL_B_W-1:0] ALPHA_Q16     = 17'sd328;
  localparam logic signed [SPEED_W-1:0] SNAP_Q16      = 24'sd328;
  localparam logic signed [UPD_W-1:0]   SPEED_MAX     = 34'sd8388607;
  localparam logic signed [UPD_W-1:0]   SPEED_MIN     = -34'sd8388608;
  localparam logic [THR_W-1:0]          THR_RESET     = 15'd205;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_LINEAR    = 2'd0,
    CFG_GAIN_ANGULAR   = 2'd1,
    CFG_DIST_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_SQX  = 3'd0,
    MUL_SQY  = 3'd1,
    MUL_SQZ  = 3'd2,
    MUL_SQT  = 3'd3,
    MUL_LIN  = 3'd4,
    MUL_ANG  = 3'd5,
    MUL_DIFF = 3'd6
  } mul_sel_t;

  typedef struct packed {
    logic     start;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     far_ld;
    logic     diff_ld;
    logic     sel_ang;
    logic     mem_ld;
    logic     out_ld;
  } fvc_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } fvc_stat_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 20'sd51472;
      5'd1:    val = 20'sd30386;
      5'd2:    val = 20'sd16055;
      5'd3:    val = 20'sd8150;
      5'd4:    val = 20'sd4091;
      5'd5:    val = 20'sd2047;
      5'd6:    val = 20'sd1024;
      5'd7:    val = 20'sd512;
      5'd8:    val = 20'sd256;
      5'd9:    val = 20'sd128;
      5'd10:   val = 20'sd64;
      5'd11:   val = 20'sd32;
      5'd12:   val = 20'sd16;
      5'd13:   val = 20'sd8;
      5'd14:   val = 20'sd4;
      5'd15:   val = 20'sd2;
      5'd16:   val = 20'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/fvc_if.sv =====
// Valid/ready channel interfaces for the point pair input and the speed result.
// Depends on fvc_pkg for the field widths.
interface fvc_in_if;
  import fvc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] start_x;
  logic signed [POS_W-1:0] start_y;
  logic signed [POS_W-1:0] start_z;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;

  modport source (output valid, start_x, start_y, start_z, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, target_x, target_y, target_z,
                output ready);
endinterface

interface fvc_out_if;
  import fvc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] linear_velocity;
  logic signed [SPEED_W-1:0] angular_velocity;

  modport source (output valid, linear_velocity, angular_velocity, input ready);
  modport sink (input valid, linear_velocity, angular_velocity, output ready);
endinterface

// ===== design/follow_velocity_controller_core.sv =====
// Top level of the follow velocity controller: valid/ready channels, the
// configuration write port, controller and datapath. Depends on fvc_pkg,
// fvc_if, fvc_ctrl and fvc_datapath.
//
// One item is handled at a time. The time from the input transfer to the
// result being offered is set by the heading CORDIC, which performs one
// rotation per cycle while the shared multiplier works through the squares
// and the linear filter. The result sits in an output register, so a waiting
// result does not block the next input transfer, only the finish of the item
// after it. Configuration writes take effect at once and should be made while
// no item is in flight.
module follow_velocity_controller_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fvc_pkg::CFG_W-1:0]     cfg_data,
  fvc_in_if.sink                        in_chan,
  fvc_out_if.source                     out_chan
);
  import fvc_pkg::*;

  fvc_cmd_t  cmd;
  fvc_stat_t stat;

  fvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fvc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .start_x          (in_chan.start_x),
    .start_y          (in_chan.start_y),
    .start_z          (in_chan.start_z),
    .target_x         (in_chan.target_x),
    .target_y         (in_chan.target_y),
    .target_z         (in_chan.target_z),
    .linear_velocity  (out_chan.linear_velocity),
    .angular_velocity (out_chan.angular_velocity)
  );

endmodule

// ===== design/fvc_cordic.sv =====
// Iterative vectoring CORDIC that finds the planar heading of the error vector,
// one rotation per cycle. Depends on fvc_pkg for widths and the arctangent table.
module fvc_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [fvc_pkg::ERR_W-1:0] ex,
  input  logic signed [fvc_pkg::ERR_W-1:0] ey,
  output logic signed [fvc_pkg::ANG_W-1:0] phi,
  output logic                           done
);
  import fvc_pkg::*;

  logic signed [CV_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [CV_W-1:0]  x0, y0, xs, ys;
  logic signed [ANG_W-1:0] z_r, z_nxt, at;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt, done_r, done_nxt;
  logic                    last;

  assign x0   = CV_W'(ex) <<< CV_SHIFT;
  assign y0   = CV_W'(ey) <<< CV_SHIFT;
  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign at   = atan_q16(ATAN_IDX_W'(cnt_r));
  assign last = (cnt_r == STEP_W'(CORDIC_STEPS - 1));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      if (ex < 0) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = (ey >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end else if (y_r < 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end
      cnt_nxt = cnt_r + STEP_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign phi  = z_r;
  assign done = done_r;

`ifndef ASSERT_OFF
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && last && !start) |=> (done_r && !busy_r))
    else $error("CORDIC did not finish after its last rotation");
`endif

endmodule

// ===== design/fvc_datapath.sv =====
// Datapath: configuration registers, error vector, shared multiplier, length
// accumulator, filter memories and result registers. Depends on fvc_pkg, fvc_cordic.
module fvc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fvc_pkg::fvc_cmd_t                  cmd,
  output fvc_pkg::fvc_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [fvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fvc_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [fvc_pkg::POS_W-1:0]   start_x,
  input  logic signed [fvc_pkg::POS_W-1:0]   start_y,
  input  logic signed [fvc_pkg::POS_W-1:0]   start_z,
  input  logic signed [fvc_pkg::POS_W-1:0]   target_x,
  input  logic signed [fvc_pkg::POS_W-1:0]   target_y,
  input  logic signed [fvc_pkg::POS_W-1:0]   target_z,
  output logic signed [fvc_pkg::SPEED_W-1:0] linear_velocity,
  output logic signed [fvc_pkg::SPEED_W-1:0] angular_velocity
);
  import fvc_pkg::*;

  localparam logic signed [PROD_W-1:0] LIN_BIAS  = PROD_W'(1) <<< (LIN_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] ANG_BIAS  = PROD_W'(1) <<< (ANG_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] FILT_BIAS = PROD_W'(1) <<< (FILT_SHIFT - 1);

  logic signed [GAIN_W-1:0]  gain_lin_r, gain_ang_r;
  logic [THR_W-1:0]          thr_r;
  logic signed [ERR_W-1:0]   ex_nxt, ey_nxt, ez_nxt, ex_r, ey_r, ez_r;
  logic signed [ANG_W-1:0]   phi;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt, prod_r;
  logic [LEN_W-1:0]          acc_r, sq_ext;
  logic                      far_r, drive_r, drive_sel, heading_ok;
  logic signed [SPEED_W-1:0] mem_sel, mem_nxt, lin_mem_r, ang_mem_r;
  logic signed [SPEED_W-1:0] out_lin_r, out_ang_r;
  logic signed [PROD_W-1:0]  lin_wide, ang_wide, filt_wide;
  logic signed [DIFF_W-1:0]  diff_nxt, diff_r;
  logic signed [UPD_W-1:0]   filt_step, upd_sum;
  logic                      snap;

  assign ex_nxt = ERR_W'(target_x) - ERR_W'(start_x);
  assign ey_nxt = ERR_W'(target_y) - ERR_W'(start_y);
  assign ez_nxt = ERR_W'(target_z) - ERR_W'(start_z);

  fvc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .ex    (ex_nxt),
    .ey    (ey_nxt),
    .phi   (phi),
    .done  (stat.cordic_done)
  );

  always_comb begin
    case (cmd.mul_sel)
      MUL_SQX: begin
        mul_a = MUL_A_W'(ex_r);
        mul_b = MUL_B_W'(ex_r);
      end
      MUL_SQY: begin
        mul_a = MUL_A_W'(ey_r);
        mul_b = MUL_B_W'(ey_r);
      end
      MUL_SQZ: begin
        mul_a = MUL_A_W'(ez_r);
        mul_b = MUL_B_W'(ez_r);
      end
      MUL_SQT: begin
        mul_a = $signed({{(MUL_A_W - THR_W){1'b0}}, thr_r});
        mul_b = $signed({{(MUL_B_W - THR_W){1'b0}}, thr_r});
      end
      MUL_LIN: begin
        mul_a = MUL_A_W'(ex_r);
        mul_b = MUL_B_W'(gain_lin_r);
      end
      MUL_ANG: begin
        mul_a = MUL_A_W'(phi);
        mul_b = MUL_B_W'(gain_ang_r);
      end
      MUL_DIFF: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = ALPHA_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign sq_ext   = LEN_W'(prod_r[SQ_W-1:0]);

  assign mem_sel    = cmd.sel_ang ? ang_mem_r : lin_mem_r;
  assign heading_ok = (phi > -HEADING_LIMIT) && (phi < HEADING_LIMIT);
  assign drive_sel  = cmd.sel_ang ? (far_r && heading_ok) : far_r;

  assign lin_wide = (prod_r + LIN_BIAS - (PROD_W'(mem_sel) <<< LIN_SHIFT)) >>> LIN_SHIFT;
  assign ang_wide = (prod_r + ANG_BIAS - (PROD_W'(mem_sel) <<< ANG_SHIFT)) >>> ANG_SHIFT;

  always_comb begin
    if (!drive_sel) begin
      diff_nxt = DIFF_W'(mem_sel);
    end else if (cmd.sel_ang) begin
      diff_nxt = ang_wide[DIFF_W-1:0];
    end else begin
      diff_nxt = lin_wide[DIFF_W-1:0];
    end
  end

  assign filt_wide = (prod_r + FILT_BIAS) >>> FILT_SHIFT;
  assign filt_step = filt_wide[UPD_W-1:0];
  assign upd_sum   = drive_r ? (UPD_W'(mem_sel) + filt_step) : (UPD_W'(mem_sel) - filt_step);
  assign snap      = !drive_r && (mem_sel >= -SNAP_Q16) && (mem_sel <= SNAP_Q16);

  always_comb begin
    if (snap) begin
      mem_nxt = '0;
    end else if (upd_sum > SPEED_MAX) begin
      mem_nxt = SPEED_MAX[SPEED_W-1:0];
    end else if (upd_sum < SPEED_MIN) begin
      mem_nxt = SPEED_MIN[SPEED_W-1:0];
    end else begin
      mem_nxt = upd_sum[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_lin_r <= '0;
      gain_ang_r <= '0;
      thr_r      <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_LINEAR:    gain_lin_r <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_ANGULAR:   gain_ang_r <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_DIST_THRESHOLD: thr_r      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.start) begin
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
      ez_r  <= ez_nxt;
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + sq_ext;
    end
    if (cmd.far_ld) begin
      far_r <= (acc_r > sq_ext);
    end
    if (cmd.diff_ld) begin
      diff_r  <= diff_nxt;
      drive_r <= drive_sel;
    end
    if (cmd.out_ld) begin
      out_lin_r <= lin_mem_r;
      out_ang_r <= ang_mem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_mem_r <= '0;
      ang_mem_r <= '0;
    end else if (cmd.mem_ld) begin
      if (cmd.sel_ang) begin
        ang_mem_r <= mem_nxt;
      end else begin
        lin_mem_r <= mem_nxt;
      end
    end
  end

  assign linear_velocity  = out_lin_r;
  assign angular_velocity = out_ang_r;

endmodule

// ===== design/fvc_ctrl.sv =====
// Controller state machine that sequences the shared multiplier, the filters
// and the handshakes of both channels. Depends on fvc_pkg.
module fvc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fvc_pkg::fvc_cmd_t  cmd,
  input  fvc_pkg::fvc_stat_t stat
);
  import fvc_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SQX   = 14'b00000000000010,
    ST_SQY   = 14'b00000000000100,
    ST_SQZ   = 14'b00000000001000,
    ST_SQT   = 14'b00000000010000,
    ST_MLIN  = 14'b00000000100000,
    ST_TLIN  = 14'b00000001000000,
    ST_MFLIN = 14'b00000010000000,
    ST_ULIN  = 14'b00000100000000,
    ST_MANG  = 14'b00001000000000,
    ST_TANG  = 14'b00010000000000,
    ST_MFANG = 14'b00100000000000,
    ST_UANG  = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.mul_sel = MUL_SQX;
        state_nxt   = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_sel = MUL_SQY;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.mul_sel = MUL_SQZ;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SQT;
      end
      ST_SQT: begin
        cmd.mul_sel = MUL_SQT;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_MLIN;
      end
      ST_MLIN: begin
        cmd.mul_sel = MUL_LIN;
        cmd.far_ld  = 1'b1;
        state_nxt   = ST_TLIN;
      end
      ST_TLIN: begin
        cmd.diff_ld = 1'b1;
        state_nxt   = ST_MFLIN;
      end
      ST_MFLIN: begin
        cmd.mul_sel = MUL_DIFF;
        state_nxt   = ST_ULIN;
      end
      ST_ULIN: begin
        cmd.mem_ld = 1'b1;
        state_nxt  = ST_MANG;
      end
      ST_MANG: begin
        cmd.mul_sel = MUL_ANG;
        if (stat.cordic_done) begin
          state_nxt = ST_TANG;
        end
      end
      ST_TANG: begin
        cmd.diff_ld = 1'b1;
        cmd.sel_ang = 1'b1;
        state_nxt   = ST_MFANG;
      end
      ST_MFANG: begin
        cmd.mul_sel = MUL_DIFF;
        state_nxt   = ST_UANG;
      end
      ST_UANG: begin
        cmd.mem_ld  = 1'b1;
        cmd.sel_ang = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SQX))
    else $error("Input transfer did not start the sequence");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("Result register loaded while a result is still pending");
  a_wait_heading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MANG && !stat.cordic_done) |=> (state_r == ST_MANG))
    else $error("Angular path left before the heading was ready");
`endif

endmodule

// ===== dv/tb_follow_velocity_controller_core.sv =====
// Testbench for follow_velocity_controller_core: directed and random point pairs, each
// speed transfer checked against a built-in fixed-point model of the heading and filters.
// Depends on fvc_pkg, the fvc_in_if/fvc_out_if interfaces and the core RTL.
module tb_follow_velocity_controller_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fvc_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] sz;
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [POS_W-1:0] tz;
  } point_pair_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] lin;
    logic signed [SPEED_W-1:0] ang;
  } speeds_t;

  typedef enum {MIXED, NEAR_HEAVY, AHEAD_HEAVY} lean_t;
  typedef enum {SHAPE_WIDE, SHAPE_NEAR, SHAPE_AHEAD, SHAPE_EDGE, SHAPE_BEHIND, SHAPE_ZERO} shape_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int     ROTATIONS   = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
  localparam longint TURN_PI     = 205887;
  localparam longint TURN_LIMIT  = 102892;
  localparam longint SMOOTH      = 328;
  localparam longint REST_BAND   = 328;
  localparam longint TOP_SPEED   = 8388607;
  localparam longint BOT_SPEED   = -8388608;
  localparam int     CYCLE_LIMIT = 500000;
  localparam longint ARCTAN [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2,
                                     1, 0, 0, 0, 0, 0, 0, 0};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  fvc_in_if  in_chan();
  fvc_out_if out_chan();

  follow_velocity_controller_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  point_pair_t pending[$];
  speeds_t     speeds_due[$];
  point_pair_t next_pair;
  point_pair_t seen_pair;
  speeds_t     want;
  int issued = 0;
  int accepted = 0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int hold_off = 0;
  bit calm;

  longint gain_lin;
  longint gain_ang;
  longint thr_cfg;
  longint lin_mem;
  longint ang_mem;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_speed(longint v);
    if (v > TOP_SPEED) return TOP_SPEED;
    if (v < BOT_SPEED) return BOT_SPEED;
    return v;
  endfunction

  function automatic longint approach(longint mem, longint goal);
    return clamp_speed(mem + round_shift((goal - mem) * SMOOTH, 16));
  endfunction

  function automatic longint fade(longint mem);
    if (mem > REST_BAND || mem < -REST_BAND) begin
      return clamp_speed(mem - round_shift(mem * SMOOTH, 16));
    end
    return 0;
  endfunction

  function automatic longint heading_of(longint ex, longint ey);
    longint x, y, z, xs, ys;
    int i;
    x = ex * 256;
    y = ey * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (ey >= 0) ? TURN_PI : -TURN_PI;
    end
    for (i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN[i];
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN[i];
      end
    end
    return z;
  endfunction

  // Advances both filter memories by one control tick.
  function automatic speeds_t next_speeds(point_pair_t p);
    longint ex, ey, ez, len2, phi, aphi;
    logic far;
    speeds_t r;
    ex = longint'($signed(p.tx)) - longint'($signed(p.sx));
    ey = longint'($signed(p.ty)) - longint'($signed(p.sy));
    ez = longint'($signed(p.tz)) - longint'($signed(p.sz));
    len2 = ex * ex + ey * ey + ez * ez;
    far = len2 > thr_cfg * thr_cfg;
    phi = heading_of(ex, ey);
    aphi = (phi < 0) ? -phi : phi;
    lin_mem = far ? approach(lin_mem, round_shift(gain_lin * ex, 4)) : fade(lin_mem);
    if (far && aphi < TURN_LIMIT) begin
      ang_mem = approach(ang_mem, round_shift(gain_ang * phi, 8));
    end else begin
      ang_mem = fade(ang_mem);
    end
    r.lin = lin_mem[SPEED_W-1:0];
    r.ang = ang_mem[SPEED_W-1:0];
    return r;
  endfunction

  function automatic point_pair_t pair(int a, int b, int c, int d, int e, int f);
    point_pair_t p;
    p.sx = 16'(a);
    p.sy = 16'(b);
    p.sz = 16'(c);
    p.tx = 16'(d);
    p.ty = 16'(e);
    p.tz = 16'(f);
    return p;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic point_pair_t random_pair(lean_t lean);
    point_pair_t p;
    shape_t shape;
    int roll, r, sx, sy, sz;
    roll = $urandom_range(0, 9);
    if (roll < 3) shape = SHAPE_WIDE;
    else if (roll < 5) shape = SHAPE_NEAR;
    else if (roll < 7) shape = SHAPE_AHEAD;
    else if (roll == 7) shape = SHAPE_EDGE;
    else if (roll == 8) shape = SHAPE_BEHIND;
    else shape = SHAPE_ZERO;
    if (lean == NEAR_HEAVY && $urandom_range(0, 1) == 1) shape = SHAPE_NEAR;
    if (lean == AHEAD_HEAVY && $urandom_range(0, 3) != 0) shape = SHAPE_AHEAD;
    sx = spread(16000);
    sy = spread(16000);
    sz = spread(16000);
    r = (thr_cfg * 2 + 8 > 16000) ? 16000 : int'(thr_cfg * 2 + 8);
    case (shape)
      SHAPE_WIDE: p = {$urandom(), $urandom(), $urandom()};
      SHAPE_NEAR: p = pair(sx, sy, sz, sx + spread(r), sy + spread(r), sz + spread(r));
      SHAPE_AHEAD: begin
        p = pair(sx, sy, sz, sx + int'($urandom_range(1, 16383)), sy + spread(16383),
                 sz + spread(2000));
      end
      SHAPE_EDGE: begin
        p = pair(sx, sy, sz, sx + int'($urandom_range(0, 40)),
                 sy + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(8000, 16383)), sz);
      end
      SHAPE_BEHIND: begin
        p = pair(sx, sy, sz, sx - int'($urandom_range(1, 16383)), sy + spread(16383),
                 sz + spread(500));
      end
      default: p = pair(sx, sy, sz, sx, sy, sz);
    endcase
    return p;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic queue_pair(input point_pair_t p);
    pending.push_back(p);
    issued++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (accepted != issued || speeds_due.size() != 0) @(posedge clk);
  endtask

  // Called at a rising edge; the write lands on the next one.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_GAIN_LINEAR) gain_lin = longint'($signed(data));
    else if (idx == CFG_GAIN_ANGULAR) gain_ang = longint'($signed(data));
    else if (idx == CFG_DIST_THRESHOLD) thr_cfg = longint'(data[THR_W-1:0]);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] gl, input logic [CFG_W-1:0] ga,
                           input logic [CFG_W-1:0] thr, input int count,
                           input lean_t lean, input bit quiet);
    drain();
    set_reg(CFG_GAIN_LINEAR, gl);
    set_reg(CFG_GAIN_ANGULAR, ga);
    set_reg(CFG_DIST_THRESHOLD, thr);
    cfg_we <= 1'b0;
    calm = quiet;
    repeat (count) queue_pair(random_pair(lean));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_chan.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 11);
        in_chan.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        next_pair = pending.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.start_x <= next_pair.sx;
        in_chan.start_y <= next_pair.sy;
        in_chan.start_z <= next_pair.sz;
        in_chan.target_x <= next_pair.tx;
        in_chan.target_y <= next_pair.ty;
        in_chan.target_z <= next_pair.tz;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_chan.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_off <= $urandom_range(0, 11);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // The result side is checked before a new transfer is predicted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (speeds_due.size() == 0) begin
          note_error("speed transfer with no point pair outstanding");
        end else begin
          want = speeds_due.pop_front();
          if (out_chan.linear_velocity !== want.lin) begin
            note_error($sformatf("linear_velocity %0d, expected %0d",
                                 out_chan.linear_velocity, $signed(want.lin)));
          end
          if (out_chan.angular_velocity !== want.ang) begin
            note_error($sformatf("angular_velocity %0d, expected %0d",
                                 out_chan.angular_velocity, $signed(want.ang)));
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        seen_pair = {in_chan.start_x, in_chan.start_y, in_chan.start_z,
                     in_chan.target_x, in_chan.target_y, in_chan.target_z};
        speeds_due.push_back(next_speeds(seen_pair));
        accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL follow_velocity_controller_core");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.start_x = '0;
    in_chan.start_y = '0;
    in_chan.start_z = '0;
    in_chan.target_x = '0;
    in_chan.target_y = '0;
    in_chan.target_z = '0;
    out_chan.ready = 1'b0;
    gain_lin = 0;
    gain_ang = 0;
    thr_cfg = 205;
    lin_mem = 0;
    ang_mem = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_reg(CFG_UNUSED, 16'h5A5A);
    set_reg(CFG_GAIN_LINEAR, 16'sd256);
    set_reg(CFG_GAIN_ANGULAR, 16'sd256);
    cfg_we <= 1'b0;

    // The threshold still holds its reset value here.
    queue_pair(pair(0, 0, 0, 0, 0, 0));
    queue_pair(pair(-32768, -32768, -32768, -32768, -32768, -32768));
    queue_pair(pair(-32768, -32768, -32768, 32767, 32767, 32767));
    queue_pair(pair(32767, 32767, 32767, -32768, -32768, -32768));
    queue_pair(pair(100, 0, 0, -900, 0, 0));
    queue_pair(pair(0, 0, 0, -3000, 2000, 0));
    queue_pair(pair(0, 0, 0, -3000, -2000, 0));
    queue_pair(pair(0, 0, 0, 4000, 0, 0));
    queue_pair(pair(0, 0, 0, 0, 5000, 0));
    queue_pair(pair(0, 0, 0, 0, -5000, 0));
    queue_pair(pair(0, 0, 0, 12, 16000, 0));
    queue_pair(pair(0, 0, 0, 14, 16000, 0));
    queue_pair(pair(0, 0, -20000, 0, 0, 20000));
    queue_pair(pair(0, 0, 0, 205, 0, 0));
    queue_pair(pair(0, 0, 0, 206, 0, 0));
    queue_pair(pair(1000, -1000, 0, 1000, -1000, 100));
    queue_pair(pair(32767, -32768, 0, 32767, -32768, 0));
    queue_pair(pair(-32768, 32767, -32768, 32767, -32768, 32767));
    queue_pair(pair(0, 0, 0, -1, 0, 0));

    run_phase(16'h7FFF, 16'h7FFF, 16'd0, 60, AHEAD_HEAVY, 1'b0);
    run_phase(16'h8000, 16'h8000, 16'h83E8, 60, AHEAD_HEAVY, 1'b0);
    run_phase(16'd3, 16'hFFFE, 16'd300, 200, NEAR_HEAVY, 1'b0);
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 32767)), 300, MIXED,
              1'b0);
    run_phase(16'd0, 16'd0, 16'h7FFF, 100, MIXED, 1'b1);
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 4000)), 250, MIXED,
              1'b0);
    run_phase(16'($urandom()), 16'($urandom()), 16'd205, 150, MIXED, 1'b1);

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS follow_velocity_controller_core");
    end else begin
      $display("FAIL follow_velocity_controller_core");
    end
    $finish;
  end

endmodule
